[design/ttb_pkg.sv]
`timescale 1ns / 1ps

package ttb_pkg;

    // operation codes carried in tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // bank select carried in tuser
    localparam logic BANK_FAST = 1'b0;
    localparam logic BANK_SLOW = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_STARTUP_RELOAD   = 3'd0;
    localparam logic [2:0] REG_STARTUP_SLOT     = 3'd1;
    localparam logic [2:0] REG_PRESS_TICKS      = 3'd2;
    localparam logic [2:0] REG_LONG_PRESS_TICKS = 3'd3;
    localparam logic [2:0] REG_RELEASE_TICKS    = 3'd4;

    // configuration reset values
    localparam logic [15:0] STARTUP_RELOAD_RST   = 16'd1000;
    localparam logic [2:0]  STARTUP_SLOT_RST     = 3'd0;
    localparam logic [7:0]  PRESS_TICKS_RST      = 8'd3;
    localparam logic [7:0]  LONG_PRESS_TICKS_RST = 8'd200;
    localparam logic [7:0]  RELEASE_TICKS_RST    = 8'd3;

    // slow tick every tenth millisecond tick
    localparam logic [3:0] PRESCALE_LAST = 4'd9;

    // debounce counters saturate here
    localparam logic [7:0] COUNT_CAP = 8'd250;

    typedef struct packed {
        logic press;
        logic long_press;
        logic released;
    } btn_flags_t;

endpackage

[design/ttb_timer_store.sv]
`timescale 1ns / 1ps

module ttb_timer_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int TW    = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [TW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [TW-1:0] wr_data
);

    logic [TW-1:0]    mem_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [TW-1:0]    rd_data_reg;
    logic             rd_vld_reg;

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // per-entry valid bits stand in for the all-zero reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

[design/ttb_debounce.sv]
`timescale 1ns / 1ps

module ttb_debounce (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic                pressed,
    input  logic [7:0]          press_ticks,
    input  logic [7:0]          long_press_ticks,
    input  logic [7:0]          release_ticks,
    output ttb_pkg::btn_flags_t flags
);

    logic [7:0]          pressed_cnt_reg, pressed_cnt_next;
    logic [7:0]          released_cnt_reg, released_cnt_next;
    ttb_pkg::btn_flags_t flags_reg, flags_next;
    logic [7:0]          pressed_inc;
    logic [7:0]          released_inc;

    // saturating counts
    assign pressed_inc  = (pressed_cnt_reg < ttb_pkg::COUNT_CAP) ?
                          pressed_cnt_reg + 8'd1 : pressed_cnt_reg;
    assign released_inc = (released_cnt_reg < ttb_pkg::COUNT_CAP) ?
                          released_cnt_reg + 8'd1 : released_cnt_reg;

    always_comb begin
        pressed_cnt_next  = pressed_cnt_reg;
        released_cnt_next = released_cnt_reg;
        flags_next        = flags_reg;
        if (fire) begin
            if (pressed) begin
                pressed_cnt_next = pressed_inc;
                if (pressed_inc >= press_ticks) begin
                    released_cnt_next   = 8'd0;
                    flags_next.released = 1'b0;
                    flags_next.press    = 1'b1;
                end
                if (pressed_inc >= long_press_ticks) begin
                    flags_next.long_press = 1'b1;
                end
            end else begin
                released_cnt_next = released_inc;
                if (released_inc >= release_ticks) begin
                    flags_next.press      = 1'b0;
                    flags_next.long_press = 1'b0;
                    flags_next.released   = 1'b1;
                    pressed_cnt_next      = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_cnt_reg  <= 8'd0;
            released_cnt_reg <= 8'd0;
            flags_reg        <= '0;
        end else begin
            pressed_cnt_reg  <= pressed_cnt_next;
            released_cnt_reg <= released_cnt_next;
            flags_reg        <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

[design/tick_timer_bank_button_debounce.sv]
`timescale 1ns / 1ps
// sequence: a load word shows its result in the cycle after acceptance; a tick word passes
//   S_SWEEP (slow timers too on every tenth tick), S_DEB_RD, S_DEB, S_RES_RD, S_RES, S_OUT
// flow: one word at a time, the next taken only after the result is accepted, set by the
//   single decrementer walking the timer ram
// reset: aresetn synchronous active low; timers, prescaler, debounce state and configuration
//   registers return to their reset values at once, no clearing pass

module tick_timer_bank_button_debounce #(
    parameter int FAST_TIMER_COUNT = 8,
    parameter int SLOW_TIMER_COUNT = 8,
    parameter int TIMER_WIDTH      = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // timer_index[2:0], load_value[18:3], button_level[19], zero pad
    input  logic [1:0]  s_tuser,   // operation[0], bank[1]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // timer_value[15:0], timer_expired[16], press_flag[17],
                                   // long_press_flag[18], released_flag[19], zero pad
);

    localparam int DEPTH = FAST_TIMER_COUNT + SLOW_TIMER_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = TIMER_WIDTH;

    // one-hot sequencer states
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SWEEP  = 9'b000000010,
        S_DEB_RD = 9'b000000100,
        S_DEB    = 9'b000001000,
        S_RES_RD = 9'b000010000,
        S_RES    = 9'b000100000,
        S_OUT    = 9'b001000000,
        S_SPARE0 = 9'b010000000,
        S_SPARE1 = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [15:0] startup_reload_reg;
    logic [2:0]  startup_slot_reg;
    logic [7:0]  press_ticks_reg;
    logic [7:0]  long_press_ticks_reg;
    logic [7:0]  release_ticks_reg;

    // sequencer registers
    logic [3:0]    prescale_reg, prescale_next;
    logic          slow_reg, slow_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] end_reg, end_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          slot_ok_reg, slot_ok_next;
    logic          button_reg, button_next;
    logic          deb_en_reg, deb_en_next;
    logic [TW-1:0] res_value_reg, res_value_next;

    // input word fields
    logic          in_op;
    logic          in_bank;
    logic [2:0]    in_idx;
    logic [15:0]   in_load;
    logic          in_button;
    logic          in_slot_ok;
    logic [AW-1:0] in_addr;
    logic [TW-1:0] load_masked;

    // timer ram port and shared decrementer
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [TW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [TW-1:0] wr_data;
    logic [TW-1:0] dec_value;

    // button window
    logic                window_ok;
    logic [AW-1:0]       startup_addr;
    logic [TW-1:0]       reload_masked;
    logic                deb_fire;
    ttb_pkg::btn_flags_t flags;

    assign in_op     = s_tuser[0];
    assign in_bank   = s_tuser[1];
    assign in_idx    = s_tdata[2:0];
    assign in_load   = s_tdata[18:3];
    assign in_button = s_tdata[19];

    // fast timers sit at the bottom of the ram, slow timers above them
    assign in_slot_ok = (in_bank == ttb_pkg::BANK_FAST) ?
                        (int'(in_idx) < FAST_TIMER_COUNT) :
                        (int'(in_idx) < SLOW_TIMER_COUNT);
    assign in_addr    = (in_bank == ttb_pkg::BANK_FAST) ? AW'(in_idx) :
                        AW'(FAST_TIMER_COUNT) + AW'(in_idx);
    assign load_masked   = TW'(in_load);
    assign reload_masked = TW'(startup_reload_reg);

    assign window_ok    = int'(startup_slot_reg) < SLOW_TIMER_COUNT;
    assign startup_addr = AW'(FAST_TIMER_COUNT) + AW'(startup_slot_reg);

    // the shared decrementer: decrement unless already expired
    assign dec_value = (rd_data == '0) ? rd_data : rd_data - TW'(1);

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_reload_reg   <= ttb_pkg::STARTUP_RELOAD_RST;
            startup_slot_reg     <= ttb_pkg::STARTUP_SLOT_RST;
            press_ticks_reg      <= ttb_pkg::PRESS_TICKS_RST;
            long_press_ticks_reg <= ttb_pkg::LONG_PRESS_TICKS_RST;
            release_ticks_reg    <= ttb_pkg::RELEASE_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                ttb_pkg::REG_STARTUP_RELOAD:   startup_reload_reg   <= cfg_wdata;
                ttb_pkg::REG_STARTUP_SLOT:     startup_slot_reg     <= cfg_wdata[2:0];
                ttb_pkg::REG_PRESS_TICKS:      press_ticks_reg      <= cfg_wdata[7:0];
                ttb_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_wdata[7:0];
                ttb_pkg::REG_RELEASE_TICKS:    release_ticks_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        prescale_next  = prescale_reg;
        slow_next      = slow_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        addr_next      = addr_reg;
        slot_ok_next   = slot_ok_reg;
        button_next    = button_reg;
        deb_en_next    = deb_en_reg;
        res_value_next = res_value_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        deb_fire       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    addr_next    = in_addr;
                    slot_ok_next = in_slot_ok;
                    button_next  = in_button;
                    if (in_op == ttb_pkg::OP_LOAD) begin
                        // load: one write if the slot exists, no tick
                        wr_en          = in_slot_ok;
                        wr_addr        = in_addr;
                        wr_data        = load_masked;
                        res_value_next = in_slot_ok ? load_masked : '0;
                        state_next     = S_OUT;
                    end else begin
                        // tick: advance prescaler, start walking the ram at entry 0
                        if (prescale_reg == ttb_pkg::PRESCALE_LAST) begin
                            prescale_next = 4'd0;
                            slow_next     = 1'b1;
                            end_next      = AW'(DEPTH - 1);
                        end else begin
                            prescale_next = prescale_reg + 4'd1;
                            slow_next     = 1'b0;
                            end_next      = AW'(FAST_TIMER_COUNT - 1);
                        end
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        ptr_next   = '0;
                        state_next = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                // write back entry ptr while the next one is read
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = dec_value;
                if (ptr_reg == end_reg) begin
                    state_next = S_DEB_RD;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + AW'(1);
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_DEB_RD: begin
                deb_en_next = slow_reg && window_ok;
                rd_en       = slow_reg && window_ok;
                rd_addr     = startup_addr;
                state_next  = S_DEB;
            end
            S_DEB: begin
                // window open while the startup timer is still running
                if (deb_en_reg && (rd_data != '0)) begin
                    deb_fire = 1'b1;
                    if (button_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = startup_addr;
                        wr_data = reload_masked;
                    end
                end
                state_next = S_RES_RD;
            end
            S_RES_RD: begin
                rd_en      = slot_ok_reg;
                rd_addr    = addr_reg;
                state_next = S_RES;
            end
            S_RES: begin
                res_value_next = slot_ok_reg ? rd_data : '0;
                state_next     = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            prescale_reg <= 4'd0;
            slow_reg     <= 1'b0;
            ptr_reg      <= '0;
            end_reg      <= '0;
            slot_ok_reg  <= 1'b0;
            deb_en_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prescale_reg <= prescale_next;
            slow_reg     <= slow_next;
            ptr_reg      <= ptr_next;
            end_reg      <= end_next;
            slot_ok_reg  <= slot_ok_next;
            deb_en_reg   <= deb_en_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        button_reg    <= button_next;
        res_value_reg <= res_value_next;
    end

    ttb_timer_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .TW    (TW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ttb_debounce u_debounce (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .fire             (deb_fire),
        .pressed          (button_reg),
        .press_ticks      (press_ticks_reg),
        .long_press_ticks (long_press_ticks_reg),
        .release_ticks    (release_ticks_reg),
        .flags            (flags)
    );

    // handshake and result word
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {4'd0, flags.released, flags.long_press, flags.press,
                       (res_value_reg == '0), 16'(res_value_reg)};

    // never takes a word while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while result pending");

    // a result appears only after a load or after the result read
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == S_RES || $past(state_reg) == S_IDLE))
        else $error("result word without completed sequence");

    // sweep pointer stays within the walked range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP) |-> (ptr_reg <= end_reg))
        else $error("sweep pointer past end");

    // prescaler stays below ten
    assert property (@(posedge aclk) disable iff (!aresetn)
        prescale_reg <= ttb_pkg::PRESCALE_LAST)
        else $error("prescaler out of range");

    // debouncer only runs on a slow tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        deb_fire |-> slow_reg)
        else $error("debounce outside slow tick");

endmodule
